[hdl/q24alu_pkg.sv]
`timescale 1ns / 1ps

package q24alu_pkg;

  localparam int unsigned IN_WIDTH           = 32;
  localparam int unsigned DEF_WORD_WIDTH     = 32;
  localparam int unsigned DEF_FRACTION_BITS  = 8;

  typedef enum logic [3:0] {
    MODE_ADD      = 4'd0,
    MODE_SUB      = 4'd1,
    MODE_MUL      = 4'd2,
    MODE_DIV      = 4'd3,
    MODE_LT       = 4'd4,
    MODE_GT       = 4'd5,
    MODE_LE       = 4'd6,
    MODE_GE       = 4'd7,
    MODE_EQ       = 4'd8,
    MODE_NE       = 4'd9,
    MODE_MIN      = 4'd10,
    MODE_MAX      = 4'd11,
    MODE_INC      = 4'd12,
    MODE_DEC      = 4'd13,
    MODE_FROM_INT = 4'd14,
    MODE_TO_INT   = 4'd15
  } mode_t;

endpackage

[hdl/q24_8_fixed_point_alu_core.sv]
`timescale 1ns / 1ps
// channel   | ports                                        | dir
// request   | start, in_mode, in_operand_a/b; busy is out  | in
// result    | out_valid, out_result_value, out_compare_true,| out
//           | out_overflow, out_divide_by_zero             |
// one request per cycle; busy is never raised
// out_valid is registered through the input stage, the multiply and magnitude
// stage, the divider chain (one cell per quotient bit) and the result register,
// for every mode
// results are strobed by out_valid for one cycle; the receiver cannot stall
// reset is synchronous, active low, and clears only the valid bits

module q24_8_fixed_point_alu_core
  import q24alu_pkg::*;
#(
  parameter int unsigned WORD_WIDTH    = DEF_WORD_WIDTH,
  parameter int unsigned FRACTION_BITS = DEF_FRACTION_BITS
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       start,
  output logic                       busy,
  input  logic [3:0]                 in_mode,
  input  logic signed [IN_WIDTH-1:0] in_operand_a,
  input  logic signed [IN_WIDTH-1:0] in_operand_b,
  output logic                       out_valid,
  output logic signed [IN_WIDTH-1:0] out_result_value,
  output logic                       out_compare_true,
  output logic                       out_overflow,
  output logic                       out_divide_by_zero
);

  localparam int unsigned W  = WORD_WIDTH;
  localparam int unsigned F  = FRACTION_BITS;
  localparam int unsigned D  = W + F;
  localparam int unsigned EW = 2 * W + 2;
  localparam int unsigned PW = 4 + 4 * W + 1;

  // input stage
  logic                v0_r;
  logic [3:0]          mode0_r;
  logic signed [W-1:0] a0_r, b0_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v0_r <= 1'b0;
    end else begin
      v0_r <= start;
    end
  end

  always_ff @(posedge clk) begin
    mode0_r <= in_mode;
    a0_r    <= W'(in_operand_a);
    b0_r    <= W'(in_operand_b);
  end

  // multiply and magnitude stage
  logic                  v1_r;
  logic [3:0]            mode1_r;
  logic signed [W-1:0]   a1_r, b1_r;
  logic signed [2*W-1:0] prod1_r;
  logic [W-1:0]          aabs1_r, babs1_r;
  logic                  dneg1_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
    end else begin
      v1_r <= v0_r;
    end
  end

  always_ff @(posedge clk) begin
    mode1_r <= mode0_r;
    a1_r    <= a0_r;
    b1_r    <= b0_r;
    prod1_r <= (2*W)'(a0_r) * (2*W)'(b0_r);
    aabs1_r <= a0_r[W-1] ? W'(-a0_r) : W'(a0_r);
    babs1_r <= b0_r[W-1] ? W'(-b0_r) : W'(b0_r);
    dneg1_r <= a0_r[W-1] ^ b0_r[W-1];
  end

  // divider chain
  logic          cv  [D+1];
  logic [W-1:0]  crem[D+1];
  logic [D-1:0]  cnq [D+1];
  logic [W-1:0]  cden[D+1];
  logic [PW-1:0] cpay[D+1];

  assign cv[0]   = v1_r;
  assign crem[0] = '0;
  assign cnq[0]  = {aabs1_r, {F{1'b0}}};
  assign cden[0] = babs1_r;
  assign cpay[0] = {mode1_r, a1_r, b1_r, prod1_r, dneg1_r};

  for (genvar i = 0; i < D; i++) begin : g_cell
    q24alu_div_cell #(.WW(W), .DW(D), .PW(PW)) u_cell (
      .clk  (clk),
      .rst_n(rst_n),
      .vld_i(cv[i]),
      .rem_i(crem[i]),
      .nq_i (cnq[i]),
      .den_i(cden[i]),
      .pay_i(cpay[i]),
      .vld_o(cv[i+1]),
      .rem_o(crem[i+1]),
      .nq_o (cnq[i+1]),
      .den_o(cden[i+1]),
      .pay_o(cpay[i+1])
    );
  end

  // result stage
  logic [3:0]            fmode;
  logic signed [W-1:0]   fa, fb;
  logic signed [2*W-1:0] fprod;
  logic                  fdneg;
  logic [2*W-1:0]        pmag;
  logic [2*W:0]          mq;
  logic [D:0]            dq;
  logic                  rnd;
  logic signed [EW-1:0]  ea, eb, exact;
  logic                  cmp, is_cmp, dz, ovf;
  logic signed [W-1:0]   wres;

  always_comb begin
    {fmode, fa, fb, fprod, fdneg} = cpay[D];
    ea     = EW'(fa);
    eb     = EW'(fb);
    pmag   = fprod[2*W-1] ? (2*W)'(-fprod) : (2*W)'(fprod);
    mq     = ({1'b0, pmag} + ((2*W+1)'(1) << (F - 1))) >> F;
    rnd    = ({crem[D], 1'b0} >= {1'b0, cden[D]});
    dq     = {1'b0, cnq[D]} + (D+1)'(rnd);
    exact  = '0;
    cmp    = 1'b0;
    is_cmp = 1'b0;
    dz     = 1'b0;
    case (fmode)
      MODE_ADD: exact = ea + eb;
      MODE_SUB: exact = ea - eb;
      MODE_MUL: exact = fprod[2*W-1] ? -EW'(mq) : EW'(mq);
      MODE_DIV: begin
        if (fb == '0) begin
          dz    = 1'b1;
          exact = ea;
        end else begin
          exact = fdneg ? -EW'(dq) : EW'(dq);
        end
      end
      MODE_LT: begin is_cmp = 1'b1; cmp = (fa <  fb); end
      MODE_GT: begin is_cmp = 1'b1; cmp = (fa >  fb); end
      MODE_LE: begin is_cmp = 1'b1; cmp = (fa <= fb); end
      MODE_GE: begin is_cmp = 1'b1; cmp = (fa >= fb); end
      MODE_EQ: begin is_cmp = 1'b1; cmp = (fa == fb); end
      MODE_NE: begin is_cmp = 1'b1; cmp = (fa != fb); end
      MODE_MIN:      exact = (fa < fb) ? ea : eb;
      MODE_MAX:      exact = (fa > fb) ? ea : eb;
      MODE_INC:      exact = ea + EW'(1);
      MODE_DEC:      exact = ea - EW'(1);
      MODE_FROM_INT: exact = ea <<< F;
      MODE_TO_INT:   exact = ea >>> F;
      default:       exact = '0;
    endcase
    wres = exact[W-1:0];
    ovf  = !is_cmp && (exact != EW'(wres));
  end

  logic                       ov_r;
  logic signed [IN_WIDTH-1:0] res_r;
  logic                       cmp_r, ovf_r, dz_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ov_r <= 1'b0;
    end else begin
      ov_r <= cv[D];
    end
  end

  always_ff @(posedge clk) begin
    res_r <= IN_WIDTH'(wres);
    cmp_r <= cmp;
    ovf_r <= ovf;
    dz_r  <= dz;
  end

  assign busy               = 1'b0;
  assign out_valid          = ov_r;
  assign out_result_value   = res_r;
  assign out_compare_true   = cmp_r;
  assign out_overflow       = ovf_r;
  assign out_divide_by_zero = dz_r;

`ifndef SYNTHESIS
  a_dz_clean: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_divide_by_zero |-> !out_overflow && !out_compare_true)
    else $error("divide by zero result carries other flags");
  a_cmp_clean: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_compare_true |-> out_result_value == '0 && !out_overflow)
    else $error("comparison result carries a value");
  a_strobe_src: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(cv[D]))
    else $error("result strobe without an item leaving the chain");
`endif

endmodule

[hdl/q24alu_div_cell.sv]
`timescale 1ns / 1ps

module q24alu_div_cell
  import q24alu_pkg::*;
#(
  parameter int unsigned WW = DEF_WORD_WIDTH,
  parameter int unsigned DW = DEF_WORD_WIDTH + DEF_FRACTION_BITS,
  parameter int unsigned PW = 8
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          vld_i,
  input  logic [WW-1:0] rem_i,
  input  logic [DW-1:0] nq_i,
  input  logic [WW-1:0] den_i,
  input  logic [PW-1:0] pay_i,
  output logic          vld_o,
  output logic [WW-1:0] rem_o,
  output logic [DW-1:0] nq_o,
  output logic [WW-1:0] den_o,
  output logic [PW-1:0] pay_o
);

  logic          vld_r;
  logic [WW-1:0] rem_r, rem_nxt;
  logic [DW-1:0] nq_r, nq_nxt;
  logic [WW-1:0] den_r;
  logic [PW-1:0] pay_r;
  logic [WW:0]   rem_sh;
  logic [WW:0]   diff;
  logic          ge;

  // one restoring step: bring down the next dividend bit
  always_comb begin
    rem_sh  = {rem_i, nq_i[DW-1]};
    ge      = (rem_sh >= {1'b0, den_i});
    diff    = rem_sh - {1'b0, den_i};
    rem_nxt = ge ? diff[WW-1:0] : rem_sh[WW-1:0];
    nq_nxt  = {nq_i[DW-2:0], ge};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= vld_i;
    end
  end

  always_ff @(posedge clk) begin
    rem_r <= rem_nxt;
    nq_r  <= nq_nxt;
    den_r <= den_i;
    pay_r <= pay_i;
  end

  assign vld_o = vld_r;
  assign rem_o = rem_r;
  assign nq_o  = nq_r;
  assign den_o = den_r;
  assign pay_o = pay_r;

endmodule
